[hw/rtl/gradient_edge_threshold_stream_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the gradient edge threshold stream
// Shared forms for concurrent checks: same-cycle and next-cycle implication.
// ---------------------------------------------------------------------------
`ifndef GRADIENT_EDGE_THRESHOLD_STREAM_MACROS_SVH
`define GRADIENT_EDGE_THRESHOLD_STREAM_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GETST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define GETST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/getst_pkg.sv]
// ---------------------------------------------------------------------------
// getst_pkg
// Types and constants shared by the gradient edge threshold stream modules.
// ---------------------------------------------------------------------------
package getst_pkg;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_DRAIN = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_KERNEL_MODE  = 2'd2,
      REG_THRESHOLD    = 2'd3
   } reg_index_type;

   localparam int unsigned PIXEL_BITS    = 8;
   localparam int unsigned WIDTH_BITS    = 11;
   localparam int unsigned HEIGHT_BITS   = 16;
   localparam int unsigned THRESH_BITS   = 9;
   localparam int unsigned CSR_IDX_BITS  = 2;
   localparam int unsigned CSR_DATA_BITS = 16;

   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;
   localparam logic                   KERNEL_RESET = 1'b1;
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 9'd128;

   localparam logic [PIXEL_BITS-1:0] EDGE_ON  = 8'd255;
   localparam logic [PIXEL_BITS-1:0] EDGE_OFF = 8'd0;

   // gradient arithmetic widths
   localparam int unsigned SUM_BITS  = 10;  // |weighted sum| <= 1020
   localparam int unsigned PROD_BITS = 20;  // 1020 * 683
   localparam int unsigned QUOT_BITS = 9;   // <= 340
   localparam int unsigned SQ_BITS   = 17;  // 340^2
   localparam int unsigned LIM_BITS  = 19;  // 512^2

   // x / 3 == (x * 683) >> 11 for 0 <= x < 1024
   localparam logic [SUM_BITS-1:0] RECIP_3     = 10'd683;
   localparam int unsigned         RECIP_SHIFT = 11;

   typedef struct packed {
      logic emit;   // item gives a result
      logic zero;   // border or drain: result forced to 0
      logic last;   // final result of the frame
   } tag_type;

   typedef struct packed {
      logic                  emit;
      logic                  last;
      logic [PIXEL_BITS-1:0] edge_value;
   } result_type;

endpackage

[hw/rtl/getst_req_if.sv]
// ---------------------------------------------------------------------------
// getst_req_if
// Request channel: command and pixel with valid/ready handshake.
// ---------------------------------------------------------------------------
interface getst_req_if;
   logic                              valid;
   logic                              ready;
   logic                              cmd;
   logic [getst_pkg::PIXEL_BITS-1:0] pixel;

   modport source (output valid, cmd, pixel, input ready);
   modport sink   (input valid, cmd, pixel, output ready);
endinterface

[hw/rtl/getst_rsp_if.sv]
// ---------------------------------------------------------------------------
// getst_rsp_if
// Result channel: edge value and frame marker with valid/ready handshake.
// ---------------------------------------------------------------------------
interface getst_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [getst_pkg::PIXEL_BITS-1:0] edge_value;
   logic                              frame_last;

   modport source (output valid, edge_value, frame_last, input ready);
   modport sink   (input valid, edge_value, frame_last, output ready);
endinterface

[hw/rtl/getst_line_mem.sv]
// ---------------------------------------------------------------------------
// getst_line_mem
// Two line stores packed in one synchronous RAM with a written-prefix mark
// and write-to-read forwarding.
// ---------------------------------------------------------------------------
module getst_line_mem #(
   parameter int unsigned MAX_LINE_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rd_en,
   input  logic [$clog2(MAX_LINE_WIDTH)-1:0]   rd_col,
   input  logic                                wr_en,
   input  logic [getst_pkg::PIXEL_BITS-1:0]    wr_px,
   output logic [getst_pkg::PIXEL_BITS-1:0]    up,
   output logic [getst_pkg::PIXEL_BITS-1:0]    mid
);
   import getst_pkg::*;

   localparam int unsigned AW = $clog2(MAX_LINE_WIDTH);
   localparam int unsigned DW = 2 * PIXEL_BITS;

   // entry = {upper row, middle row}
   logic [DW-1:0]         mem [MAX_LINE_WIDTH];
   logic [DW-1:0]         rdata_ff;
   logic [AW-1:0]         col_ff;
   logic                  hit_ff;
   logic                  fwd_ff;
   logic [PIXEL_BITS-1:0] fwd_up_ff;
   logic [PIXEL_BITS-1:0] fwd_mid_ff;
   logic [AW:0]           hw_ff;   // columns below this were written

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_col];
      end
      if (wr_en) begin
         mem[col_ff] <= {mid, wr_px};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         col_ff     <= rd_col;
         fwd_up_ff  <= mid;
         fwd_mid_ff <= wr_px;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff  <= '0;
         hit_ff <= 1'b0;
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         hit_ff <= {1'b0, rd_col} < hw_ff;
         // same entry written in this very cycle: RAM returns old data
         fwd_ff <= wr_en && (rd_col == col_ff);
         if ({1'b0, rd_col} >= hw_ff) begin
            hw_ff <= {1'b0, rd_col} + 1'b1;
         end
      end
   end

   // never-written entries read as zero
   always_comb begin
      if (fwd_ff) begin
         up  = fwd_up_ff;
         mid = fwd_mid_ff;
      end else if (hit_ff) begin
         up  = rdata_ff[DW-1:PIXEL_BITS];
         mid = rdata_ff[PIXEL_BITS-1:0];
      end else begin
         up  = '0;
         mid = '0;
      end
   end

endmodule

[hw/rtl/getst_seq.sv]
// ---------------------------------------------------------------------------
// getst_seq
// Input column, owed-result count and output position counters.
// ---------------------------------------------------------------------------
module getst_seq #(
   parameter int unsigned MAX_LINE_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic                                 cmd,
   input  logic                                 restart,
   input  logic [getst_pkg::WIDTH_BITS-1:0]     frame_width,
   input  logic [getst_pkg::HEIGHT_BITS-1:0]    frame_height,
   output logic [$clog2(MAX_LINE_WIDTH)-1:0]    col,
   output getst_pkg::tag_type                   tag
);
   import getst_pkg::*;

   localparam int unsigned AW = $clog2(MAX_LINE_WIDTH);
   localparam int unsigned WW = $clog2(MAX_LINE_WIDTH + 1);
   localparam int unsigned CW = (WW > WIDTH_BITS) ? WW : WIDTH_BITS;
   localparam int unsigned PW = $clog2(MAX_LINE_WIDTH + 3);
   localparam int unsigned XW = CW + 1;
   localparam logic [CW-1:0] MAX_W = CW'(MAX_LINE_WIDTH);

   logic [AW-1:0]          col_ff,  col_in;
   logic [PW-1:0]          pend_ff, pend_in;
   logic [AW-1:0]          ocol_ff, ocol_in;
   logic [HEIGHT_BITS-1:0] orow_ff, orow_in;

   logic [CW-1:0]          w_raw, w_eff;
   logic [HEIGHT_BITS-1:0] h_eff;
   logic [CW-1:0]          col_nx, ocol_nx;
   logic [HEIGHT_BITS:0]   orow_nx;
   logic                   col_wrap, ocol_wrap, orow_wrap;
   logic                   is_pixel, over, emit, border;

   always_comb begin
      w_raw = CW'(frame_width);
      if (w_raw == '0) begin
         w_eff = CW'(1);
      end else if (w_raw > MAX_W) begin
         w_eff = MAX_W;
      end else begin
         w_eff = w_raw;
      end
      h_eff = (frame_height == '0) ? HEIGHT_BITS'(1) : frame_height;

      is_pixel  = (cmd == CMD_PIXEL);
      col_nx    = CW'(col_ff) + CW'(1);
      col_wrap  = col_nx >= w_eff;
      ocol_nx   = CW'(ocol_ff) + CW'(1);
      ocol_wrap = ocol_nx >= w_eff;
      orow_nx   = {1'b0, orow_ff} + 1'b1;
      orow_wrap = orow_nx >= {1'b0, h_eff};

      // pixel pushes out a result once more than width are owed
      over   = XW'(pend_ff) > XW'(w_eff);
      emit   = accept && (is_pixel ? over : (pend_ff != '0));
      border = (orow_ff == '0) || orow_wrap || (ocol_ff == '0) || ocol_wrap;

      tag.emit = emit;
      tag.zero = !is_pixel || border;
      tag.last = ocol_wrap && orow_wrap;

      col_in  = col_ff;
      pend_in = pend_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      if (accept) begin
         if (is_pixel) begin
            col_in = col_wrap ? '0 : AW'(col_nx);
            if (!over) begin
               pend_in = pend_ff + 1'b1;
            end
         end else if (emit) begin
            pend_in = pend_ff - 1'b1;
         end
      end
      if (emit) begin
         ocol_in = ocol_wrap ? '0 : AW'(ocol_nx);
         if (ocol_wrap) begin
            orow_in = orow_wrap ? '0 : orow_nx[HEIGHT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff  <= '0;
         pend_ff <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
      end else begin
         col_ff  <= col_in;
         pend_ff <= pend_in;
         ocol_ff <= ocol_in;
         orow_ff <= orow_in;
      end
   end

   assign col = col_ff;

endmodule

[hw/rtl/getst_grad.sv]
// ---------------------------------------------------------------------------
// getst_grad
// 3x3 window, Prewitt/Sobel gradients, divide by 3, squared magnitude
// against the square of threshold+1. Four registered stages.
// ---------------------------------------------------------------------------
module getst_grad (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  logic                                 shift,
   input  logic [getst_pkg::PIXEL_BITS-1:0]     up,
   input  logic [getst_pkg::PIXEL_BITS-1:0]     mid,
   input  logic [getst_pkg::PIXEL_BITS-1:0]     px,
   input  getst_pkg::tag_type                   tag_in,
   input  logic                                 kernel_mode,
   input  logic [getst_pkg::THRESH_BITS-1:0]    threshold,
   output getst_pkg::result_type                res
);
   import getst_pkg::*;

   logic [PIXEL_BITS-1:0] win_ff [9];
   tag_type               tag2_ff, tag3_ff, tag4_ff, tag5_ff;
   logic [SUM_BITS-1:0]   ax_ff, ay_ff;
   logic [QUOT_BITS-1:0]  qx_ff, qy_ff;
   logic [SQ_BITS-1:0]    sqx_ff, sqy_ff;
   logic [LIM_BITS-1:0]   lim_ff;

   logic [SUM_BITS-1:0]   mx, my, px_pos, px_neg, py_pos, py_neg;
   logic [SUM_BITS-1:0]   ax_in, ay_in;
   logic [PROD_BITS-1:0]  prx, pry;
   logic [2*QUOT_BITS-1:0] sqx_full, sqy_full;
   logic [SUM_BITS-1:0]   thr1;
   logic [2*SUM_BITS-1:0] lim_full;
   logic [SQ_BITS:0]      mag_sq;

   // window: rows 0..2 top to bottom, columns 0..2 oldest to newest
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (adv && shift) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r*3]     <= win_ff[r*3 + 1];
            win_ff[r*3 + 1] <= win_ff[r*3 + 2];
         end
         win_ff[2] <= up;
         win_ff[5] <= mid;
         win_ff[8] <= px;
      end
   end

   always_comb begin
      mx = kernel_mode ? {1'b0, win_ff[5], 1'b0} : {2'b0, win_ff[5]};
      my = kernel_mode ? {1'b0, win_ff[7], 1'b0} : {2'b0, win_ff[7]};
      px_pos = {2'b0, win_ff[2]} + mx + {2'b0, win_ff[8]};
      mx = kernel_mode ? {1'b0, win_ff[3], 1'b0} : {2'b0, win_ff[3]};
      px_neg = {2'b0, win_ff[0]} + mx + {2'b0, win_ff[6]};
      py_pos = {2'b0, win_ff[6]} + my + {2'b0, win_ff[8]};
      my = kernel_mode ? {1'b0, win_ff[1], 1'b0} : {2'b0, win_ff[1]};
      py_neg = {2'b0, win_ff[0]} + my + {2'b0, win_ff[2]};
      // only the magnitude matters after squaring
      ax_in = (px_pos >= px_neg) ? (px_pos - px_neg) : (px_neg - px_pos);
      ay_in = (py_pos >= py_neg) ? (py_pos - py_neg) : (py_neg - py_pos);

      prx = ax_ff * RECIP_3;
      pry = ay_ff * RECIP_3;

      sqx_full = qx_ff * qx_ff;
      sqy_full = qy_ff * qy_ff;

      thr1     = {1'b0, threshold} + 1'b1;
      lim_full = thr1 * thr1;

      mag_sq = {1'b0, sqx_ff} + {1'b0, sqy_ff};

      res.emit       = tag5_ff.emit;
      res.last       = tag5_ff.last;
      res.edge_value = (!tag5_ff.zero && (LIM_BITS'(mag_sq) >= lim_ff)) ? EDGE_ON : EDGE_OFF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
         tag5_ff <= '0;
      end else if (adv) begin
         tag2_ff <= tag_in;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
         tag5_ff <= tag4_ff;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff <= LIM_BITS'(lim_full);
      if (adv) begin
         ax_ff  <= ax_in;
         ay_ff  <= ay_in;
         qx_ff  <= prx[PROD_BITS-1:RECIP_SHIFT];
         qy_ff  <= pry[PROD_BITS-1:RECIP_SHIFT];
         sqx_ff <= SQ_BITS'(sqx_full);
         sqy_ff <= SQ_BITS'(sqy_full);
      end
   end

endmodule

[hw/rtl/gradient_edge_threshold_stream.sv]
// ---------------------------------------------------------------------------
// gradient_edge_threshold_stream
// Streaming 3x3 Prewitt/Sobel edge detector with integer magnitude
// threshold, line stores in one synchronous RAM.
// ---------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req_if  | in  | valid/ready        | cmd (pixel/drain), pixel[7:0]
//  rsp_if  | out | valid/ready        | edge_value[7:0], frame_last
//  csr_*   | in  | csr_wr_en          | csr_index[1:0], csr_wdata[15:0]
//
//  One request per cycle while the pipe is not held. A result passes the RAM
//  read, window, gradient, divide and square registers, then is compared
//  and loaded into the output register.
//  No clearing pass after reset: unwritten line entries read as zero through
//  a written-column mark. Back-pressure holds the pipe only when a result
//  reaches the last stage while the output register is full and not taken.
// ---------------------------------------------------------------------------
`include "gradient_edge_threshold_stream_macros.svh"

module gradient_edge_threshold_stream #(
   parameter int unsigned MAX_LINE_WIDTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   getst_req_if.sink                             req_if,
   getst_rsp_if.source                           rsp_if,
   input  logic                                  csr_wr_en,
   input  logic [getst_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [getst_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import getst_pkg::*;

   localparam int unsigned AW = $clog2(MAX_LINE_WIDTH);

   // configuration
   logic [WIDTH_BITS-1:0]  frame_width_ff;
   logic [HEIGHT_BITS-1:0] frame_height_ff;
   logic                   kernel_mode_ff;
   logic [THRESH_BITS-1:0] threshold_ff;
   logic                   restart;

   // pipe control
   logic                   adv;
   logic                   accept;
   logic                   rd_en;
   logic [AW-1:0]          col;
   tag_type                tag0;

   // stage 1: waiting on RAM data
   logic                   s1_pix_ff;
   logic [PIXEL_BITS-1:0]  s1_px_ff;
   tag_type                s1_tag_ff;
   logic [PIXEL_BITS-1:0]  up, mid;

   result_type             res;

   // output register
   logic                   rsp_valid_ff;
   logic [PIXEL_BITS-1:0]  rsp_edge_ff;
   logic                   rsp_last_ff;

   // --- configuration writes; geometry writes restart the frame ---
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
         kernel_mode_ff  <= KERNEL_RESET;
         threshold_ff    <= THRESH_RESET;
      end else if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[WIDTH_BITS-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata[HEIGHT_BITS-1:0];
            REG_KERNEL_MODE:  kernel_mode_ff  <= csr_wdata[0];
            REG_THRESHOLD:    threshold_ff    <= csr_wdata[THRESH_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign restart = csr_wr_en && ((csr_index == REG_FRAME_WIDTH) ||
                                  (csr_index == REG_FRAME_HEIGHT));

   // --- handshake: stall only when a result meets a full output register ---
   assign adv          = !(res.emit && rsp_valid_ff && !rsp_if.ready);
   assign req_if.ready = adv;
   assign accept       = req_if.valid && adv;
   assign rd_en        = accept && (req_if.cmd == CMD_PIXEL);

   // --- stage 0: counters and result decision ---
   getst_seq #(
      .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .cmd          (req_if.cmd),
      .restart      (restart),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .col          (col),
      .tag          (tag0)
   );

   // --- line stores: read at stage 0, write back at stage 1 ---
   getst_line_mem #(
      .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
   ) u_line_mem (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (rd_en),
      .rd_col (col),
      .wr_en  (s1_pix_ff && adv),
      .wr_px  (s1_px_ff),
      .up     (up),
      .mid    (mid)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_pix_ff <= 1'b0;
         s1_tag_ff <= '0;
      end else if (adv) begin
         s1_pix_ff <= rd_en;
         s1_tag_ff <= tag0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_px_ff <= req_if.pixel;
      end
   end

   // --- window and gradient pipe ---
   getst_grad u_grad (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .shift       (s1_pix_ff),
      .up          (up),
      .mid         (mid),
      .px          (s1_px_ff),
      .tag_in      (s1_tag_ff),
      .kernel_mode (kernel_mode_ff),
      .threshold   (threshold_ff),
      .res         (res)
   );

   // --- output register ---
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && res.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && res.emit) begin
         rsp_edge_ff <= res.edge_value;
         rsp_last_ff <= res.last;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.edge_value = rsp_edge_ff;
   assign rsp_if.frame_last = rsp_last_ff;

   // --- checks ---
   `GETST_ASSERT_NOW(a_no_accept_on_block, clock, reset, res.emit && rsp_valid_ff && !rsp_if.ready, !accept, "request accepted while a result is blocked")
   `GETST_ASSERT_NEXT(a_result_loaded, clock, reset, res.emit && adv, rsp_valid_ff, "finished result not loaded into output register")
   `GETST_ASSERT_NOW(a_edge_binary, clock, reset, rsp_valid_ff, (rsp_edge_ff == EDGE_ON) || (rsp_edge_ff == EDGE_OFF), "edge value neither 0 nor 255")

endmodule
